// ----- src/rs_pkg.sv -----
// Shared types and constants for the rectangle subtract block.
// Used by rs_front, rs_fifo, rs_back and rectangle_subtract.
package rs_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

    // piece order in the mask
    localparam int PIECE_UPPER = 0;
    localparam int PIECE_LOWER = 1;
    localparam int PIECE_LEFT  = 2;
    localparam int PIECE_RIGHT = 3;
    localparam int NUM_PIECES  = 4;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [NUM_PIECES-1:0]         t_mask;

    localparam t_coord COORD_ONE  = t_coord'(1);
    localparam t_coord COORD_ZERO = t_coord'(0);

    typedef struct packed {
        t_coord ax0;
        t_coord ay0;
        t_coord ax1;
        t_coord ay1;
        t_coord ix0;
        t_coord iy0;
        t_coord ix1;
        t_coord iy1;
        t_mask  mask;
        logic   disjoint;
    } t_item;

    typedef struct packed {
        t_coord min_x;
        t_coord min_y;
        t_coord max_x;
        t_coord max_y;
        logic   is_last;
        logic   none_left;
    } t_result;

endpackage

// ----- src/rs_front.sv -----
// Front end: accepts a rectangle pair, forms the intersection and classifies pieces.
// Depends on rs_pkg.
module rs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic           i_q_full,
    input  rs_pkg::t_coord i_a_min_x,
    input  rs_pkg::t_coord i_a_min_y,
    input  rs_pkg::t_coord i_a_max_x,
    input  rs_pkg::t_coord i_a_max_y,
    input  rs_pkg::t_coord i_b_min_x,
    input  rs_pkg::t_coord i_b_min_y,
    input  rs_pkg::t_coord i_b_max_x,
    input  rs_pkg::t_coord i_b_max_y,
    output logic           o_q_push,
    output rs_pkg::t_item  o_item
);
    import rs_pkg::*;

    logic w_overlap;

    assign w_overlap = (i_a_min_x <= i_b_max_x) && (i_a_min_y <= i_b_max_y) &&
                       (i_a_max_x >= i_b_min_x) && (i_a_max_y >= i_b_min_y);

    always_comb begin
        o_item.ax0 = i_a_min_x;
        o_item.ay0 = i_a_min_y;
        o_item.ax1 = i_a_max_x;
        o_item.ay1 = i_a_max_y;
        o_item.ix0 = (i_a_min_x > i_b_min_x) ? i_a_min_x : i_b_min_x;
        o_item.iy0 = (i_a_min_y > i_b_min_y) ? i_a_min_y : i_b_min_y;
        o_item.ix1 = (i_a_max_x < i_b_max_x) ? i_a_max_x : i_b_max_x;
        o_item.iy1 = (i_a_max_y < i_b_max_y) ? i_a_max_y : i_b_max_y;
        o_item.disjoint = !w_overlap;
        o_item.mask = '0;
        if (w_overlap) begin
            o_item.mask[PIECE_UPPER] = o_item.iy0 > i_a_min_y;
            o_item.mask[PIECE_LOWER] = o_item.iy1 < i_a_max_y;
            o_item.mask[PIECE_LEFT]  = o_item.ix0 > i_a_min_x;
            o_item.mask[PIECE_RIGHT] = o_item.ix1 < i_a_max_x;
        end
    end

    assign o_q_push = i_push && !i_q_full;

    a_disjoint_no_pieces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push && o_item.disjoint |-> o_item.mask == '0)
        else $error("disjoint item carries pieces");
    a_isect_inside_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push && !o_item.disjoint |-> o_item.ix0 >= o_item.ax0 && o_item.ix1 <= o_item.ax1)
        else $error("intersection leaves a in x");
    a_isect_inside_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push && !o_item.disjoint |-> o_item.iy0 >= o_item.ay0 && o_item.iy1 <= o_item.ay1)
        else $error("intersection leaves a in y");

endmodule

// ----- src/rs_fifo.sv -----
// Short queue of classified items between front and back.
// Depends on rs_pkg.
module rs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rs_pkg::t_item i_item,
    output logic          o_full,
    input  logic          i_pop,
    output rs_pkg::t_item o_item,
    output logic          o_empty
);
    import rs_pkg::*;

    t_item                r_mem [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0] r_wr_ptr;
    logic [PTR_WIDTH-1:0] r_rd_ptr;
    logic [CNT_WIDTH-1:0] r_count;
    logic [PTR_WIDTH-1:0] n_wr_ptr;
    logic [PTR_WIDTH-1:0] n_rd_ptr;

    assign o_full  = r_count == CNT_WIDTH'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_WIDTH'(QUEUE_DEPTH))
        else $error("queue count over depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");

endmodule

// ----- src/rs_back.sv -----
// Back end: walks an item's pieces, one rectangle per cycle unless stalled.
// Depends on rs_pkg.
module rs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rs_pkg::t_item   i_q_item,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output rs_pkg::t_result o_res
);
    import rs_pkg::*;

    logic    r_busy;
    t_item   r_cur;
    t_mask   r_rem;
    logic    r_ov;
    t_result r_res;

    logic    w_emit;
    logic    w_last;
    t_mask   w_sel;
    t_result w_res;

    assign w_emit = r_busy && (!r_ov || i_pop);

    always_comb begin
        w_sel = '0;
        if (!r_cur.disjoint) begin
            if (r_rem[PIECE_UPPER]) begin
                w_sel[PIECE_UPPER] = 1'b1;
            end else if (r_rem[PIECE_LOWER]) begin
                w_sel[PIECE_LOWER] = 1'b1;
            end else if (r_rem[PIECE_LEFT]) begin
                w_sel[PIECE_LEFT] = 1'b1;
            end else if (r_rem[PIECE_RIGHT]) begin
                w_sel[PIECE_RIGHT] = 1'b1;
            end
        end
    end

    assign w_last = r_cur.disjoint || ((r_rem & ~w_sel) == '0);

    always_comb begin
        w_res.is_last   = w_last;
        w_res.none_left = 1'b0;
        w_res.min_x     = r_cur.ax0;
        w_res.min_y     = r_cur.ay0;
        w_res.max_x     = r_cur.ax1;
        w_res.max_y     = r_cur.ay1;
        if (!r_cur.disjoint) begin
            if (w_sel[PIECE_UPPER]) begin
                w_res.max_y = t_coord'(r_cur.iy0 - COORD_ONE);
            end else if (w_sel[PIECE_LOWER]) begin
                w_res.min_y = t_coord'(r_cur.iy1 + COORD_ONE);
            end else if (w_sel[PIECE_LEFT]) begin
                w_res.min_y = r_cur.iy0;
                w_res.max_x = t_coord'(r_cur.ix0 - COORD_ONE);
                w_res.max_y = r_cur.iy1;
            end else if (w_sel[PIECE_RIGHT]) begin
                w_res.min_x = t_coord'(r_cur.ix1 + COORD_ONE);
                w_res.min_y = r_cur.iy0;
                w_res.max_y = r_cur.iy1;
            end else begin
                w_res.none_left = 1'b1;
                w_res.min_x     = COORD_ZERO;
                w_res.min_y     = COORD_ZERO;
                w_res.max_x     = COORD_ZERO;
                w_res.max_y     = COORD_ZERO;
            end
        end
    end

    assign o_q_pop = !i_q_empty && (!r_busy || (w_emit && w_last));

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_item;
        end
        if (w_emit) begin
            r_res <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rem  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_rem  <= i_q_item.mask;
            end else if (w_emit && w_last) begin
                r_busy <= 1'b0;
            end else if (w_emit) begin
                r_rem <= r_rem & ~w_sel;
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_empty = !r_ov;
    assign o_res   = r_res;

    a_more_pieces_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && !w_last |=> r_busy)
        else $error("item dropped before its last piece");
    a_one_piece: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && !r_cur.disjoint && r_rem != '0 |-> $onehot(w_sel))
        else $error("piece select not one-hot");
    a_none_left_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_res.none_left |-> r_res.is_last && r_res.min_x == COORD_ZERO &&
            r_res.max_y == COORD_ZERO)
        else $error("covered result malformed");

endmodule

// ----- src/rectangle_subtract.sv -----
// Top level of the rectangle subtract block: front classifier, item queue, piece emitter.
// Depends on rs_pkg, rs_front, rs_fifo and rs_back.
//
// Each accepted pair (a, b) yields one to four result rectangles, one per cycle on the
// result port while its result register is empty or popped; the last carries is_last.
// An item has 1 piece when a and b are disjoint or b covers a, up to 4 otherwise, and
// that single result port sets the sustained rate. A two-entry queue sits between the
// classifier and the emitter, so input is taken while results wait. When the block is
// drained, an item passes the queue, the item register and then the result register.
module rectangle_subtract (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  rs_pkg::t_coord i_a_min_x,
    input  rs_pkg::t_coord i_a_min_y,
    input  rs_pkg::t_coord i_a_max_x,
    input  rs_pkg::t_coord i_a_max_y,
    input  rs_pkg::t_coord i_b_min_x,
    input  rs_pkg::t_coord i_b_min_y,
    input  rs_pkg::t_coord i_b_max_x,
    input  rs_pkg::t_coord i_b_max_y,
    output logic           empty,
    input  logic           pop,
    output rs_pkg::t_coord o_out_min_x,
    output rs_pkg::t_coord o_out_min_y,
    output rs_pkg::t_coord o_out_max_x,
    output rs_pkg::t_coord o_out_max_y,
    output logic           o_is_last,
    output logic           o_none_left
);
    import rs_pkg::*;

    logic    w_q_push;
    logic    w_q_full;
    logic    w_q_pop;
    logic    w_q_empty;
    t_item   w_front_item;
    t_item   w_head_item;
    t_result w_res;

    rs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_q_full  (w_q_full),
        .i_a_min_x (i_a_min_x),
        .i_a_min_y (i_a_min_y),
        .i_a_max_x (i_a_max_x),
        .i_a_max_y (i_a_max_y),
        .i_b_min_x (i_b_min_x),
        .i_b_min_y (i_b_min_y),
        .i_b_max_x (i_b_max_x),
        .i_b_max_y (i_b_max_y),
        .o_q_push  (w_q_push),
        .o_item    (w_front_item)
    );

    rs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_item  (w_head_item),
        .o_empty (w_q_empty)
    );

    rs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_item  (w_head_item),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (w_res)
    );

    assign full        = w_q_full;
    assign o_out_min_x = w_res.min_x;
    assign o_out_min_y = w_res.min_y;
    assign o_out_max_x = w_res.max_x;
    assign o_out_max_y = w_res.max_y;
    assign o_is_last   = w_res.is_last;
    assign o_none_left = w_res.none_left;

endmodule

// ----- tb/sv/rectangle_subtract_test.sv -----
// Self-checking testbench for rectangle_subtract: directed and random rectangle pairs,
// with an in-bench piece predictor and random idling on both queue sides.
// Depends on rs_pkg and the rectangle_subtract RTL.
module rectangle_subtract_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rs_pkg::*;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   push;
    logic   full;
    t_coord i_a_min_x, i_a_min_y, i_a_max_x, i_a_max_y;
    t_coord i_b_min_x, i_b_min_y, i_b_max_x, i_b_max_y;
    logic   empty;
    logic   pop;
    t_coord o_out_min_x, o_out_min_y, o_out_max_x, o_out_max_y;
    logic   o_is_last;
    logic   o_none_left;

    t_result expected_pieces[$];
    int      failures;
    int      pairs_sent;
    int      pieces_checked;
    int      covered_seen;
    int      full_stall_cycles;
    int      hold_request;
    bit      idle_in;
    bit      idle_out;

    rectangle_subtract dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_a_min_x   (i_a_min_x),
        .i_a_min_y   (i_a_min_y),
        .i_a_max_x   (i_a_max_x),
        .i_a_max_y   (i_a_max_y),
        .i_b_min_x   (i_b_min_x),
        .i_b_min_y   (i_b_min_y),
        .i_b_max_x   (i_b_max_x),
        .i_b_max_y   (i_b_max_y),
        .empty       (empty),
        .pop         (pop),
        .o_out_min_x (o_out_min_x),
        .o_out_min_y (o_out_min_y),
        .o_out_max_x (o_out_max_x),
        .o_out_max_y (o_out_max_y),
        .o_is_last   (o_is_last),
        .o_none_left (o_none_left)
    );

    always #10ns i_clk = ~i_clk;

    function automatic void predict_pieces(input t_coord ax0, ay0, ax1, ay1,
                                           input t_coord bx0, by0, bx1, by1);
        t_coord  ix0, iy0, ix1, iy1;
        t_mask   m;
        t_result r;
        if (!(ax0 <= bx1 && ay0 <= by1 && ax1 >= bx0 && ay1 >= by0)) begin
            expected_pieces.push_back('{ax0, ay0, ax1, ay1, 1'b1, 1'b0});
            return;
        end
        ix0 = (ax0 > bx0) ? ax0 : bx0;
        iy0 = (ay0 > by0) ? ay0 : by0;
        ix1 = (ax1 < bx1) ? ax1 : bx1;
        iy1 = (ay1 < by1) ? ay1 : by1;
        m = '0;
        m[PIECE_UPPER] = iy0 > ay0;
        m[PIECE_LOWER] = iy1 < ay1;
        m[PIECE_LEFT]  = ix0 > ax0;
        m[PIECE_RIGHT] = ix1 < ax1;
        if (m == '0) begin
            expected_pieces.push_back('{COORD_ZERO, COORD_ZERO, COORD_ZERO, COORD_ZERO,
                                        1'b1, 1'b1});
            return;
        end
        for (int p = 0; p < NUM_PIECES; p++) begin
            if (m[p]) begin
                case (p)
                    PIECE_UPPER: r = '{ax0, ay0, ax1, t_coord'(iy0 - COORD_ONE), 1'b0, 1'b0};
                    PIECE_LOWER: r = '{ax0, t_coord'(iy1 + COORD_ONE), ax1, ay1, 1'b0, 1'b0};
                    PIECE_LEFT:  r = '{ax0, iy0, t_coord'(ix0 - COORD_ONE), iy1, 1'b0, 1'b0};
                    default:     r = '{t_coord'(ix1 + COORD_ONE), iy0, ax1, iy1, 1'b0, 1'b0};
                endcase
                r.is_last = ((m >> (p + 1)) == '0);
                expected_pieces.push_back(r);
            end
        end
    endfunction

    task automatic send_pair(input t_coord ax0, ay0, ax1, ay1, input t_coord bx0, by0, bx1, by1);
        int gap;
        gap = idle_in ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_a_min_x <= ax0;
        i_a_min_y <= ay0;
        i_a_max_x <= ax1;
        i_a_max_y <= ay1;
        i_b_min_x <= bx0;
        i_b_min_y <= by0;
        i_b_max_x <= bx1;
        i_b_max_y <= by1;
        do begin
            @(posedge i_clk);
            if (full) full_stall_cycles++;
        end while (full);
        predict_pieces(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
        pairs_sent++;
    endtask

    function automatic t_coord near(input int base);
        return t_coord'(base + int'($urandom_range(0, 32)) - 16);
    endfunction

    task automatic send_random_pair();
        t_coord c[8];
        t_coord tmp;
        int     mode;
        int     base;
        mode = $urandom_range(0, 9);
        base = int'($urandom_range(0, 65535)) - 32768;
        if ($urandom_range(0, 7) == 0) base = $urandom_range(0, 1) ? -32752 : 32751;
        if (base < -32752) base = -32752;
        if (base > 32751) base = 32751;
        for (int k = 0; k < 8; k++) begin
            if (mode <= 6)
                c[k] = near(base);
            else if (mode <= 8)
                c[k] = t_coord'($urandom);
            else
                c[k] = $urandom_range(0, 1) ? near(-32752) : near(32751);
        end
        // well-formed pairs dominate; the unsorted modes can give malformed rectangles
        if (mode <= 5 || mode == 9) begin
            for (int k = 0; k < 8; k++) begin
                if ((k % 4) < 2 && c[k] > c[k + 2]) begin
                    tmp      = c[k];
                    c[k]     = c[k + 2];
                    c[k + 2] = tmp;
                end
            end
        end
        send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endtask

    task automatic test_directed();
        idle_in  = 1'b1;
        idle_out = 1'b1;
        send_pair(0, 0, 9, 9, 20, 20, 30, 30);
        send_pair(0, 0, 9, 9, -5, -5, -1, 20);
        send_pair(0, 0, 9, 9, 9, 9, 15, 15);
        send_pair(0, 0, 9, 9, 0, 0, 9, 9);
        send_pair(0, 0, 9, 9, -1, -1, 10, 10);
        send_pair(0, 0, 9, 9, 3, 3, 6, 6);
        send_pair(0, 0, 9, 9, -1, -1, 10, 4);
        send_pair(0, 0, 9, 9, -1, 5, 10, 10);
        send_pair(0, 0, 9, 9, 5, -1, 10, 10);
        send_pair(0, 0, 9, 9, -1, -1, 4, 10);
        send_pair(0, 0, 9, 9, 9, 0, 20, 9);
        send_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
        send_pair(-32768, -32768, 32767, 32767, 0, 0, 0, 0);
        send_pair(-32768, -32768, 32767, 32767, -32768, -32768, -32768, -32768);
        send_pair(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
        send_pair(32767, 32767, 32767, 32767, -32768, -32768, 32767, 32767);
        send_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        send_pair(9, 9, 0, 0, 3, 3, 6, 6);
        send_pair(5, 0, 4, 9, 0, 0, 9, 9);
        send_pair(0, 0, 9, 9, 6, 3, 3, 6);
        send_pair(32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768);
    endtask

    task automatic test_random();
        idle_in  = 1'b1;
        idle_out = 1'b1;
        repeat (150) send_random_pair();
    endtask

    task automatic test_back_pressure();
        idle_in      = 1'b0;
        idle_out     = 1'b1;
        hold_request = 150;
        repeat (24) send_random_pair();
    endtask

    task automatic test_back_to_back();
        idle_in  = 1'b0;
        idle_out = 1'b0;
        repeat (20) send_random_pair();
    endtask

    task automatic compare_field(input string name, input t_coord want, input t_coord got);
        if (want !== got) begin
            if (failures < 10)
                $display("word %0d %s: expected %0d, got %0d", pieces_checked, name, want, got);
            failures++;
        end
    endtask

    initial begin
        int      gap;
        t_result want;
        pop <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = idle_out ? $urandom_range(0, 7) : 0;
            if (hold_request > 0) begin
                gap          = hold_request;
                hold_request = 0;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (expected_pieces.size() == 0) begin
                if (failures < 10) $display("word %0d arrived with nothing expected", pieces_checked);
                failures++;
            end else begin
                want = expected_pieces.pop_front();
                compare_field("min_x", want.min_x, o_out_min_x);
                compare_field("min_y", want.min_y, o_out_min_y);
                compare_field("max_x", want.max_x, o_out_max_x);
                compare_field("max_y", want.max_y, o_out_max_y);
                compare_field("is_last", t_coord'(want.is_last), t_coord'(o_is_last));
                compare_field("none_left", t_coord'(want.none_left), t_coord'(o_none_left));
                if (want.none_left) covered_seen++;
            end
            pieces_checked++;
        end
    end

    initial begin
        failures          = 0;
        pairs_sent        = 0;
        pieces_checked    = 0;
        covered_seen      = 0;
        full_stall_cycles = 0;
        hold_request      = 0;
        idle_in           = 1'b1;
        idle_out          = 1'b1;
        i_rst_n   <= 1'b0;
        push      <= 1'b0;
        i_a_min_x <= '0;
        i_a_min_y <= '0;
        i_a_max_x <= '0;
        i_a_max_y <= '0;
        i_b_min_x <= '0;
        i_b_min_y <= '0;
        i_b_max_x <= '0;
        i_b_max_y <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random();
        test_back_pressure();
        test_back_to_back();
        push <= 1'b0;

        while (expected_pieces.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d rectangle pairs, checked %0d pieces (%0d fully covered).",
                 pairs_sent, pieces_checked, covered_seen);
        $display("Input held off by a full queue for %0d cycles.", full_stall_cycles);
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", failures);
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout with %0d words still expected", expected_pieces.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
